@@ sv/bap_pkg.sv @@
// Shared constants, types and helpers for the block average pixelation design.
`timescale 1ns / 1ps

package bap_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int TILE_LIMIT  = 1024;

  localparam int REG_W       = 11;
  localparam int COORD_W     = 10;
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 28;
  localparam int CNT_W       = 21;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;
  localparam int COL_ADDR_W  = $clog2(MAX_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int LANES       = 4;
  localparam int STEP_W      = $clog2(SUM_W);

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE    = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] tile;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_column;
    logic [COORD_W-1:0] pixel_row;
    logic [REG_W-1:0]   tile;
    logic [CNT_W-1:0]   count;
    logic [SUM_W-1:0]   red_sum;
    logic [SUM_W-1:0]   green_sum;
    logic [SUM_W-1:0]   blue_sum;
    logic               frame_done;
  } work_t;

  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] sat_mean(input logic [SUM_W-1:0] q);
    logic [CHAN_W-1:0] r;
    if (|q[SUM_W-1:CHAN_W]) begin
      r = '1;
    end else begin
      r = q[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/block_average_pixelate.sv @@
// Top level of the block average pixelation unit with its register port.
// No new pixel is accepted while the last one is being summed, a read-modify-write of the
// block-column sum memory through its single registered read port.
// A finished block passes through a 2-entry queue to the 28-step shift-subtract divider, which
// computes the block means and loads the result register.
// Reset: counters and the queue clear, registers return to 640, 480 and 8; sums are not cleared.
`timescale 1ns / 1ps

module block_average_pixelate import bap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic [CHAN_W-1:0]  red_in,
  input  logic [CHAN_W-1:0]  green_in,
  input  logic [CHAN_W-1:0]  blue_in,
  input  logic               push,
  output logic               full,
  output logic [COORD_W-1:0] tile_column,
  output logic [COORD_W-1:0] tile_row,
  output logic [CHAN_W-1:0]  red_avg,
  output logic [CHAN_W-1:0]  green_avg,
  output logic [CHAN_W-1:0]  blue_avg,
  output logic               frame_done,
  output logic               empty,
  input  logic               pop
);

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [REG_W-1:0] tile_size;
  logic [1:0]       reg_index;
  logic             reg_write;
  cfg_t             cfg;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  work_t            q_din;
  work_t            q_dout;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_W'(640);
      image_height <= REG_W'(480);
      tile_size    <= REG_W'(8);
    end else if (reg_write) begin
      unique case (reg_index)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[REG_W-1:0];
        REG_TILE_SIZE:    tile_size    <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      REG_TILE_SIZE:    prdata = DATA_W'(tile_size);
      default:          prdata = '0;
    endcase
  end

  assign cfg.width  = clamp_reg(image_width, REG_W'(MAX_WIDTH));
  assign cfg.height = clamp_reg(image_height, REG_W'(MAX_HEIGHT));
  assign cfg.tile   = clamp_reg(tile_size, REG_W'(TILE_LIMIT));

  bap_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_din)
  );

  bap_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  bap_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_dout      (q_dout),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .tile_column (tile_column),
    .tile_row    (tile_row),
    .red_avg     (red_avg),
    .green_avg   (green_avg),
    .blue_avg    (blue_avg),
    .frame_done  (frame_done),
    .empty       (empty),
    .pop         (pop)
  );

  a_accept_blocks_next: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("input accepted while the previous pixel was still being summed");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("block transaction pushed into a full queue");

  a_no_queue_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("divider took a transaction from an empty queue");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or stall left standing after reset");

endmodule

@@ sv/bap_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bap_front.sv @@
// Front end: raster counters, block-column sum memory and block completion detection.
`timescale 1ns / 1ps

module bap_front import bap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              push,
  output logic              full,
  input  logic [CHAN_W-1:0] red_in,
  input  logic [CHAN_W-1:0] green_in,
  input  logic [CHAN_W-1:0] blue_in,
  input  logic              q_full,
  output logic              q_push,
  output work_t             q_data
);

  logic [COORD_W-1:0] pixel_column;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] offset_in_tile_x;
  logic [COORD_W-1:0] offset_in_tile_y;
  logic [COORD_W-1:0] current_tile_column;

  logic               busy;
  logic               accept;
  logic               row_end;
  logic               col_end;
  logic               tile_x_end;
  logic               tile_y_end;
  logic [REG_W-1:0]   col_inc;
  logic [REG_W-1:0]   row_inc;
  logic [REG_W-1:0]   ox_inc;
  logic [REG_W-1:0]   oy_inc;

  logic [CHAN_W-1:0]  red_l;
  logic [CHAN_W-1:0]  green_l;
  logic [CHAN_W-1:0]  blue_l;
  logic               first_l;
  logic               emit_l;
  logic               frame_done_l;
  logic [COORD_W-1:0] ox_l;
  logic [COORD_W-1:0] oy_l;
  logic [COORD_W-1:0] idx_l;
  logic [COORD_W-1:0] row_l;
  logic [REG_W-1:0]   tile_l;

  logic [3*SUM_W-1:0] rdata;
  logic [3*SUM_W-1:0] wdata;
  logic [SUM_W-1:0]   red_sum;
  logic [SUM_W-1:0]   green_sum;
  logic [SUM_W-1:0]   blue_sum;
  logic [2*REG_W-1:0] count_full;

  assign full   = busy || q_full;
  assign accept = push && !full;

  assign col_inc    = {1'b0, pixel_column} + REG_W'(1);
  assign row_inc    = {1'b0, pixel_row} + REG_W'(1);
  assign ox_inc     = {1'b0, offset_in_tile_x} + REG_W'(1);
  assign oy_inc     = {1'b0, offset_in_tile_y} + REG_W'(1);
  assign row_end    = col_inc >= cfg.width;
  assign col_end    = row_inc >= cfg.height;
  assign tile_x_end = row_end || (ox_inc >= cfg.tile);
  assign tile_y_end = col_end || (oy_inc >= cfg.tile);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      pixel_column        <= '0;
      pixel_row           <= '0;
      offset_in_tile_x    <= '0;
      offset_in_tile_y    <= '0;
      current_tile_column <= '0;
    end else begin
      busy <= accept;
      if (accept) begin
        if (row_end) begin
          pixel_column        <= '0;
          offset_in_tile_x    <= '0;
          current_tile_column <= '0;
          if (col_end) begin
            pixel_row        <= '0;
            offset_in_tile_y <= '0;
          end else begin
            pixel_row        <= pixel_row + COORD_W'(1);
            offset_in_tile_y <= tile_y_end ? '0 : offset_in_tile_y + COORD_W'(1);
          end
        end else begin
          pixel_column <= pixel_column + COORD_W'(1);
          if (tile_x_end) begin
            offset_in_tile_x    <= '0;
            current_tile_column <= current_tile_column + COORD_W'(1);
          end else begin
            offset_in_tile_x <= offset_in_tile_x + COORD_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_l        <= red_in;
      green_l      <= green_in;
      blue_l       <= blue_in;
      first_l      <= (offset_in_tile_x == '0) && (offset_in_tile_y == '0);
      emit_l       <= tile_x_end && tile_y_end;
      frame_done_l <= row_end && col_end;
      ox_l         <= offset_in_tile_x;
      oy_l         <= offset_in_tile_y;
      idx_l        <= current_tile_column;
      row_l        <= pixel_row;
      tile_l       <= cfg.tile;
    end
  end

  bap_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (busy),
    .waddr (COL_ADDR_W'(idx_l)),
    .wdata (wdata),
    .re    (accept),
    .raddr (COL_ADDR_W'(current_tile_column)),
    .rdata (rdata)
  );

  always_comb begin
    if (first_l) begin
      red_sum   = SUM_W'(red_l);
      green_sum = SUM_W'(green_l);
      blue_sum  = SUM_W'(blue_l);
    end else begin
      red_sum   = rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(red_l);
      green_sum = rdata[2*SUM_W-1:SUM_W] + SUM_W'(green_l);
      blue_sum  = rdata[SUM_W-1:0] + SUM_W'(blue_l);
    end
  end

  assign wdata      = {red_sum, green_sum, blue_sum};
  assign count_full = ({1'b0, ox_l} + REG_W'(1)) * ({1'b0, oy_l} + REG_W'(1));

  assign q_push = busy && emit_l;

  always_comb begin
    q_data.tile_column = idx_l;
    q_data.pixel_row   = row_l;
    q_data.tile        = tile_l;
    q_data.count       = count_full[CNT_W-1:0];
    q_data.red_sum     = red_sum;
    q_data.green_sum   = green_sum;
    q_data.blue_sum    = blue_sum;
    q_data.frame_done  = frame_done_l;
  end

endmodule

@@ sv/bap_queue.sv @@
// Short queue of finished blocks between the front end and the divider.
`timescale 1ns / 1ps

module bap_queue import bap_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output work_t dout,
  output logic  empty
);

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ sv/bap_back.sv @@
// Back end: shift-subtract divider for the block means and row index, and result register.
`timescale 1ns / 1ps

module bap_back import bap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  work_t              q_dout,
  input  logic               q_empty,
  output logic               q_pop,
  output logic [COORD_W-1:0] tile_column,
  output logic [COORD_W-1:0] tile_row,
  output logic [CHAN_W-1:0]  red_avg,
  output logic [CHAN_W-1:0]  green_avg,
  output logic [CHAN_W-1:0]  blue_avg,
  output logic               frame_done,
  output logic               empty,
  input  logic               pop
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;
  localparam int LANE_ROW   = 3;

  logic [1:0]         state;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   dvd      [LANES];
  logic [CNT_W-1:0]   rem      [LANES];
  logic [CNT_W-1:0]   dsr      [LANES];
  logic [SUM_W-1:0]   dvd_next [LANES];
  logic [CNT_W-1:0]   rem_next [LANES];
  logic [CNT_W:0]     trial    [LANES];
  logic [COORD_W-1:0] column_l;
  logic               frame_done_l;
  logic               out_valid;
  logic               load_out;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem[i], dvd[i][SUM_W-1]};
      if (trial[i] >= {1'b0, dsr[i]}) begin
        rem_next[i] = CNT_W'(trial[i] - {1'b0, dsr[i]});
        dvd_next[i] = {dvd[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][CNT_W-1:0];
        dvd_next[i] = {dvd[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || pop) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd[LANE_RED]   <= q_dout.red_sum;
      dvd[LANE_GREEN] <= q_dout.green_sum;
      dvd[LANE_BLUE]  <= q_dout.blue_sum;
      dvd[LANE_ROW]   <= SUM_W'(q_dout.pixel_row);
      dsr[LANE_RED]   <= q_dout.count;
      dsr[LANE_GREEN] <= q_dout.count;
      dsr[LANE_BLUE]  <= q_dout.count;
      dsr[LANE_ROW]   <= CNT_W'(q_dout.tile);
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= '0;
      end
      column_l     <= q_dout.tile_column;
      frame_done_l <= q_dout.frame_done;
    end else if (state == ST_RUN) begin
      for (int i = 0; i < LANES; i++) begin
        dvd[i] <= dvd_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tile_column <= column_l;
      tile_row    <= dvd[LANE_ROW][COORD_W-1:0];
      red_avg     <= sat_mean(dvd[LANE_RED]);
      green_avg   <= sat_mean(dvd[LANE_GREEN]);
      blue_avg    <= sat_mean(dvd[LANE_BLUE]);
      frame_done  <= frame_done_l;
    end
  end

endmodule
